### rtl/core/sdf_pkg.sv
// Shared constants, character codes and controller/datapath interface types for the formatter.
package sdf_pkg;

   // Field and payload widths
   localparam int FIELD_W       = 6;
   localparam int CHAR_W        = 8;
   localparam int MAG_W         = 32;
   localparam int DIG_N         = 10;
   localparam int NIB_W         = 4;
   localparam int BCD_W         = DIG_N * NIB_W;
   localparam int REQ_FIELDS_W  = MAG_W + 5 + 2 * FIELD_W;
   localparam int REQ_TDATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int MAX_FIELD_DEF = 63;

   // Binary to BCD conversion: bits shifted in per step and number of steps
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = MAG_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(CONV_STEPS);

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic step;
      logic measure;
      logic size;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic total_zero;
      logic last_char;
      logic out_free;
   } status_type;

endpackage

### rtl/core/sdf_bin2bcd.sv
// Iterative binary to BCD converter, four bits of the magnitude per step.
module sdf_bin2bcd (
   input  logic                     clock,
   input  logic                     load,
   input  logic                     step,
   input  logic [sdf_pkg::MAG_W-1:0] mag,
   output logic [sdf_pkg::BCD_W-1:0] bcd
);
   import sdf_pkg::*;

   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [MAG_W-1:0] bin_ff, bin_in;

   // Shift-and-add-three over four bits per step, each digit corrected before its shift
   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      if (load) begin
         bcd_in = '0;
         bin_in = mag;
      end else if (step) begin
         for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < DIG_N; d++) begin
               if (bcd_in[d*NIB_W +: NIB_W] >= 4'd5) begin
                  bcd_in[d*NIB_W +: NIB_W] = bcd_in[d*NIB_W +: NIB_W] + 4'd3;
               end
            end
            {bcd_in, bin_in} = {bcd_in[BCD_W-2:0], bin_in, 1'b0};
         end
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign bcd = bcd_ff;

endmodule

### rtl/core/sdf_dpath.sv
// Datapath: captures the request, converts, sizes the field segments and drives the output beat.
module sdf_dpath #(
   parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sdf_pkg::cmd_type               cmd,
   output sdf_pkg::status_type            status,
   input  logic [sdf_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sdf_pkg::CHAR_W-1:0]     rsp_tdata,
   output logic                           rsp_tlast,
   output logic [sdf_pkg::FIELD_W-1:0]    rsp_tuser
);
   import sdf_pkg::*;

   localparam logic [FIELD_W-1:0] WID_CAP  = FIELD_W'(MAX_FIELD);
   localparam logic [FIELD_W-1:0] PREC_CAP = FIELD_W'(MAX_FIELD - 1);

   // Request fields
   logic [MAG_W-1:0]   in_value;
   logic               in_left, in_plus, in_space, in_zpad, in_hasp;
   logic [FIELD_W-1:0] in_prec, in_wid;
   logic [MAG_W-1:0]   in_mag;

   assign in_value = req_tdata[MAG_W-1:0];
   assign in_left  = req_tdata[MAG_W];
   assign in_plus  = req_tdata[MAG_W+1];
   assign in_space = req_tdata[MAG_W+2];
   assign in_zpad  = req_tdata[MAG_W+3];
   assign in_hasp  = req_tdata[MAG_W+4];
   assign in_prec  = req_tdata[MAG_W+5 +: FIELD_W];
   assign in_wid   = req_tdata[MAG_W+5+FIELD_W +: FIELD_W];
   // Unsigned negation keeps the most negative value exact
   assign in_mag   = in_value[MAG_W-1] ? (~in_value + 1'b1) : in_value;

   // Captured flags and capped sizes
   logic               left_ff, zfill_ff, has_sign_ff;
   logic [CHAR_W-1:0]  sign_char_ff;
   logic [FIELD_W-1:0] prec_ff, wid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff     <= in_left;
         zfill_ff    <= in_zpad && !in_hasp && !in_left;
         has_sign_ff <= in_value[MAG_W-1] || in_plus || in_space;
         if (in_value[MAG_W-1]) begin
            sign_char_ff <= CHAR_MINUS;
         end else if (in_plus) begin
            sign_char_ff <= CHAR_PLUS;
         end else begin
            sign_char_ff <= CHAR_SPACE;
         end
         if (!in_hasp) begin
            prec_ff <= FIELD_W'(1);
         end else if (in_prec > PREC_CAP) begin
            prec_ff <= PREC_CAP;
         end else begin
            prec_ff <= in_prec;
         end
         wid_ff <= (in_wid > WID_CAP) ? WID_CAP : in_wid;
      end
   end

   // Decimal digits
   logic [BCD_W-1:0] bcd;

   sdf_bin2bcd u_bin2bcd (
      .clock (clock),
      .load  (cmd.load),
      .step  (cmd.step),
      .mag   (in_mag),
      .bcd   (bcd)
   );

   logic [NIB_W-1:0] nib [DIG_N];

   always_comb begin
      for (int d = 0; d < DIG_N; d++) begin
         nib[d] = bcd[d*NIB_W +: NIB_W];
      end
   end

   // Digit count: position of the top non-zero digit, none for zero at precision zero
   logic [NIB_W-1:0] ndig_ff, ndig_calc;

   always_comb begin
      ndig_calc = NIB_W'(1);
      for (int d = 0; d < DIG_N; d++) begin
         if (nib[d] != '0) begin
            ndig_calc = NIB_W'(d + 1);
         end
      end
      if (bcd == '0 && prec_ff == '0) begin
         ndig_calc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.measure) begin
         ndig_ff <= ndig_calc;
      end
   end

   // Segment boundaries of the field
   logic [FIELD_W-1:0] ndig6, dlen, body, total, pad, pzeros, lead;
   logic [FIELD_W-1:0] bnd1, bnd2, bnd3, bnd4;
   logic [FIELD_W-1:0] total_ff, b1_ff, b2_ff, b3_ff, b4_ff;

   always_comb begin
      ndig6  = FIELD_W'(ndig_ff);
      dlen   = (prec_ff > ndig6) ? prec_ff : ndig6;
      pzeros = (prec_ff > ndig6) ? (prec_ff - ndig6) : '0;
      body   = dlen + FIELD_W'(has_sign_ff);
      total  = (wid_ff > body) ? wid_ff : body;
      pad    = total - body;
      lead   = (!left_ff && !zfill_ff) ? pad : '0;
      bnd1   = lead;
      bnd2   = bnd1 + FIELD_W'(has_sign_ff);
      bnd3   = bnd2 + (zfill_ff ? pad : '0) + pzeros;
      bnd4   = bnd3 + ndig6;
   end

   // Emission position and digit pointer
   logic [FIELD_W-1:0] k_ff, k_in;
   logic [NIB_W-1:0]   didx_ff, didx_in;
   logic               digit_now;
   logic [CHAR_W-1:0]  char_now;

   assign digit_now = (k_ff >= b3_ff) && (k_ff < b4_ff);

   always_comb begin
      k_in    = k_ff;
      didx_in = didx_ff;
      if (cmd.size) begin
         k_in    = '0;
         didx_in = ndig_ff - 1'b1;
      end else if (cmd.emit) begin
         k_in = k_ff + 1'b1;
         if (digit_now) begin
            didx_in = didx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.size) begin
         total_ff <= total;
         b1_ff    <= bnd1;
         b2_ff    <= bnd2;
         b3_ff    <= bnd3;
         b4_ff    <= bnd4;
      end
      k_ff    <= k_in;
      didx_ff <= didx_in;
   end

   // Character at the current position
   always_comb begin
      if (k_ff < b1_ff) begin
         char_now = CHAR_SPACE;
      end else if (k_ff < b2_ff) begin
         char_now = sign_char_ff;
      end else if (k_ff < b3_ff) begin
         char_now = CHAR_ZERO;
      end else if (digit_now) begin
         char_now = CHAR_ZERO + CHAR_W'(nib[didx_ff]);
      end else begin
         char_now = CHAR_SPACE;
      end
   end

   // Output register: one beat held until taken
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_last_ff;
   logic [FIELD_W-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff  <= char_now;
         rsp_last_ff  <= status.last_char;
         rsp_count_ff <= status.last_char ? total_ff : '0;
      end
   end

   assign status.total_zero = (total_ff == '0);
   assign status.last_char  = (k_ff == total_ff - 1'b1);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_count_ff;

endmodule

### rtl/core/sdf_ctrl.sv
// Controller: sequences capture, conversion, sizing and character emission for one field.
module sdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sdf_pkg::status_type status,
   output sdf_pkg::cmd_type    cmd
);
   import sdf_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_MEAS = 3'd2;
   localparam logic [2:0] S_SIZE = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(CONV_STEPS - 1);

   logic [2:0]            state_ff, state_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_MEAS;
            end
         end
         S_MEAS: begin
            cmd.measure = 1'b1;
            state_in    = S_SIZE;
         end
         S_SIZE: begin
            cmd.size = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.total_zero) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_char) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### rtl/core/signed_decimal_field_formatter.sv
// Top level of the signed decimal field formatter: controller, datapath and checks.
// Formats one signed 32-bit value per request beat as a printf %d field and sends the
// characters out one per response beat, the last beat flagged by tlast and carrying the
// character count in tuser. A field that comes out empty produces no beat at all. A
// request is taken in the idle cycle, then the magnitude goes through a binary to BCD
// converter that shifts in four bits a cycle, a measure step then finds the digit count
// and a sizing step sizes the padding segments; after that one character leaves per cycle
// whenever the output register is free. The last character may still wait in the output
// register while the next request is taken.
module signed_decimal_field_formatter #(
   parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // value[31:0], left_align[32], force_plus[33], space_sign[34], zero_pad[35],
   // has_precision[36], precision[42:37], width[48:43], zero fill above
   input  logic [sdf_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // character[7:0]
   output logic [sdf_pkg::CHAR_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast,
   // total_count[5:0]
   output logic [sdf_pkg::FIELD_W-1:0]     rsp_tuser
);
   import sdf_pkg::*;

   cmd_type    cmd;
   status_type status;

   sdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sdf_dpath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // A taken request blocks the next one until its field is finished
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a field is in progress");

   // The count appears exactly on the closing beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser != '0) == rsp_tlast))
      else $error("character count not tied to the last beat");

   // Only sign, space and digit characters are ever produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >= CHAR_ZERO && rsp_tdata <= CHAR_NINE) ||
                      rsp_tdata == CHAR_SPACE || rsp_tdata == CHAR_MINUS ||
                      rsp_tdata == CHAR_PLUS))
      else $error("unexpected character on the response beat");

endmodule

### sim/tb_signed_decimal_field_formatter.sv
// Self-checking testbench for the signed decimal field formatter: directed table, then random fields.
`timescale 1ns / 100ps

module tb_signed_decimal_field_formatter;
   import sdf_pkg::*;

   localparam int MAX_FIELD    = MAX_FIELD_DEF;
   localparam int RESET_CYCLES = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 32;

   // One request beat, value in the lowest bits as on req_tdata.
   typedef struct packed {
      logic [FIELD_W-1:0] width;
      logic [FIELD_W-1:0] precision;
      logic               has_precision;
      logic               zero_pad;
      logic               space_sign;
      logic               force_plus;
      logic               left_align;
      logic [MAG_W-1:0]   value;
   } fmt_req_type;

   // One expected response beat.
   typedef struct packed {
      logic [CHAR_W-1:0]  character;
      logic               last;
      logic [FIELD_W-1:0] total_count;
   } char_beat_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // value[31:0], left_align[32], force_plus[33], space_sign[34], zero_pad[35],
   // has_precision[36], precision[42:37], width[48:43], zero fill above
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // character[7:0]
   logic [CHAR_W-1:0]      rsp_tdata;
   logic                   rsp_tlast;
   // total_count[5:0]
   logic [FIELD_W-1:0]     rsp_tuser;

   signed_decimal_field_formatter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Directed table: request, whether the field text is typed in, and that text.
   fmt_req_type dir_req[$];
   bit          dir_typed[$];
   string       dir_text[$];

   // Per offered request, in order: typed text or predictor.
   bit          pending_typed[$];
   string       pending_text[$];

   // Characters of the field being predicted, and every character still awaited.
   logic [CHAR_W-1:0] field_text[$];
   char_beat_type     expected_chars[$];

   int          sent_n      = 0;
   int          accepted_n  = 0;
   int          chars_n     = 0;
   int          errors      = 0;
   int          quiet_n     = 0;
   int          snd_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          hold_req    = 0;
   int          hold_ack    = 0;
   int          hold_left   = 0;

   fmt_req_type   acc_req;
   bit            acc_typed;
   string         acc_text;
   char_beat_type want;
   bit            moved;

   function automatic fmt_req_type mk(logic [MAG_W-1:0] value, bit left, bit plus, bit space,
                                      bit zpad, bit hasp, int prec, int wid);
      fmt_req_type r;
      r.value         = value;
      r.left_align    = left;
      r.force_plus    = plus;
      r.space_sign    = space;
      r.zero_pad      = zpad;
      r.has_precision = hasp;
      r.precision     = FIELD_W'(prec);
      r.width         = FIELD_W'(wid);
      return r;
   endfunction

   function automatic void add_row(fmt_req_type r, bit typed, string text);
      dir_req.push_back(r);
      dir_typed.push_back(typed);
      dir_text.push_back(text);
   endfunction

   // Builds the characters of one %d field into field_text.
   function automatic void format_field(fmt_req_type r);
      logic              neg;
      logic              has_sign;
      logic              zfill;
      logic [MAG_W-1:0]  mag;
      logic [CHAR_W-1:0] digs[DIG_N];
      int unsigned       prec;
      int unsigned       wid;
      int unsigned       ndig;
      int unsigned       body;
      int unsigned       total;
      int unsigned       pad;
      neg  = r.value[MAG_W-1];
      mag  = neg ? (MAG_W'(0) - r.value) : r.value;
      prec = 32'(r.precision);
      wid  = 32'(r.width);
      if (prec > MAX_FIELD - 1) prec = MAX_FIELD - 1;
      if (wid > MAX_FIELD) wid = MAX_FIELD;
      if (!r.has_precision) prec = 1;

      // Zero with an explicit precision of zero has no digits at all.
      ndig = 0;
      if (!(mag == 0 && r.has_precision && prec == 0)) begin
         do begin
            digs[ndig] = CHAR_ZERO + CHAR_W'(mag % 10);
            mag        = mag / 10;
            ndig++;
         end while (mag != 0 && ndig < DIG_N);
      end

      has_sign = neg | r.force_plus | r.space_sign;
      body     = ((prec > ndig) ? prec : ndig) + (has_sign ? 1 : 0);
      total    = (wid > body) ? wid : body;
      pad      = total - body;
      zfill    = !r.left_align && r.zero_pad && !r.has_precision;

      field_text.delete();
      if (!r.left_align && !zfill) repeat (pad) field_text.push_back(CHAR_SPACE);
      if (neg) field_text.push_back(CHAR_MINUS);
      else if (r.force_plus) field_text.push_back(CHAR_PLUS);
      else if (r.space_sign) field_text.push_back(CHAR_SPACE);
      if (zfill) repeat (pad) field_text.push_back(CHAR_ZERO);
      if (prec > ndig) repeat (prec - ndig) field_text.push_back(CHAR_ZERO);
      for (int k = ndig; k > 0; k--) field_text.push_back(digs[k-1]);
      if (r.left_align) repeat (pad) field_text.push_back(CHAR_SPACE);
   endfunction

   // Turns field_text into awaited beats; the last one carries the count.
   function automatic void queue_field();
      int n;
      char_beat_type b;
      n = field_text.size();
      for (int k = 0; k < n; k++) begin
         b.character   = field_text[k];
         b.last        = (k == n - 1);
         b.total_count = (k == n - 1) ? FIELD_W'(n) : '0;
         expected_chars.push_back(b);
      end
   endfunction

   // Offers one request beat, after a random gap, and waits until it is taken.
   task automatic send_item(fmt_req_type r, bit typed, string text);
      pending_typed.push_back(typed);
      pending_text.push_back(text);
      sent_n++;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - REQ_FIELDS_W){1'b0}}, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering and waits until every field has come out.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock);
      while (accepted_n != sent_n || expected_chars.size() != 0);
   endtask

   // Random fields: mostly short widths and precisions, values from several classes.
   task automatic run_random(int n);
      fmt_req_type      r;
      logic [MAG_W-1:0] ten;
      for (int i = 0; i < n; i++) begin
         r.left_align    = 1'($urandom_range(1));
         r.force_plus    = 1'($urandom_range(1));
         r.space_sign    = 1'($urandom_range(1));
         r.zero_pad      = 1'($urandom_range(1));
         r.has_precision = 1'($urandom_range(1));
         r.precision     = ($urandom_range(9) == 0) ? FIELD_W'($urandom_range(63))
                                                    : FIELD_W'($urandom_range(12));
         r.width         = ($urandom_range(7) == 0) ? FIELD_W'($urandom_range(63))
                                                    : FIELD_W'($urandom_range(16));
         case ($urandom_range(4))
            0: r.value = MAG_W'(int'($urandom_range(200)) - 100);
            1: r.value = $urandom();
            2: r.value = $urandom_range(1) ? (32'h8000_0000 + $urandom_range(3))
                                           : (32'h7FFF_FFFF - $urandom_range(3));
            3: begin
               // Around a power of ten, where the digit count changes.
               ten = 1;
               repeat ($urandom_range(9)) ten = ten * 10;
               r.value = ten - $urandom_range(1);
               if ($urandom_range(1)) r.value = MAG_W'(0) - r.value;
            end
            default: r.value = '0;
         endcase
         send_item(r, 1'b0, "");
      end
   endtask

   // Receiver: random back-pressure, or a long hold-off when asked for.
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack   <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Predicts on every accepted request beat and checks every response beat.
   always @(posedge clock) begin
      if (!reset) begin
         moved = req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            acc_req   = fmt_req_type'(req_tdata[REQ_FIELDS_W-1:0]);
            acc_typed = pending_typed.pop_front();
            acc_text  = pending_text.pop_front();
            if (acc_typed) begin
               field_text.delete();
               for (int k = 0; k < acc_text.len(); k++) field_text.push_back(acc_text[k]);
            end else begin
               format_field(acc_req);
            end
            queue_field();
            accepted_n++;
         end
         if (rsp_tvalid && rsp_tready) begin
            chars_n++;
            if (expected_chars.size() == 0) begin
               $error("unexpected response beat: character 0x%02h", rsp_tdata);
               errors++;
            end else begin
               moved = 1'b1;
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.character) begin
                  $error("character: expected 0x%02h, got 0x%02h", want.character, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser !== want.total_count) begin
                  $error("total_count: expected %0d, got %0d", want.total_count, rsp_tuser);
                  errors++;
               end
            end
         end
         // Watchdog on cycles in which no request is taken and no awaited beat arrives.
         if (moved) quiet_n = 0;
         else quiet_n++;
         if (quiet_n >= QUIET_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      // Typed rows: after reset, extremes and the empty field.
      add_row(mk(32'd0, 0, 0, 0, 0, 0, 0, 0), 1, "0");
      add_row(mk(32'h8000_0000, 0, 0, 0, 0, 0, 0, 0), 1, "-2147483648");
      add_row(mk(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0), 1, "2147483647");
      add_row(mk(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0), 1, "-1");
      add_row(mk(32'd0, 0, 0, 0, 0, 1, 0, 0), 1, "");
      add_row(mk(32'd0, 0, 1, 0, 0, 1, 0, 0), 1, "+");
      add_row(mk(32'd0, 0, 0, 0, 0, 1, 0, 3), 1, "   ");
      // Predicted rows: flags, padding rules and saturation.
      add_row(mk(32'd0, 1, 0, 1, 0, 1, 0, 2), 0, "");
      add_row(mk(32'd42, 0, 1, 0, 0, 0, 0, 6), 0, "");
      add_row(mk(32'd42, 1, 0, 1, 0, 0, 0, 6), 0, "");
      add_row(mk(-32'sd42, 0, 0, 0, 1, 0, 0, 8), 0, "");
      add_row(mk(-32'sd42, 1, 0, 0, 1, 0, 0, 8), 0, "");
      add_row(mk(-32'sd42, 0, 0, 0, 1, 1, 4, 8), 0, "");
      add_row(mk(32'd7, 0, 0, 0, 0, 0, 5, 0), 0, "");
      add_row(mk(32'd123, 0, 0, 0, 0, 1, 62, 0), 0, "");
      add_row(mk(32'd123, 0, 0, 0, 0, 1, 63, 0), 0, "");
      add_row(mk(32'h8000_0000, 0, 0, 0, 1, 1, 63, 63), 0, "");
      add_row(mk(32'd5, 1, 0, 0, 0, 0, 0, 63), 0, "");
      add_row(mk(32'h7FFF_FFFF, 0, 1, 0, 1, 0, 0, 63), 0, "");
      add_row(mk(32'd0, 0, 0, 1, 1, 0, 0, 63), 0, "");
      add_row(mk(32'd1_000_000_000, 0, 1, 1, 0, 0, 0, 0), 0, "");
      add_row(mk(-32'sd2147483647, 0, 0, 1, 0, 0, 0, 0), 0, "");
      add_row(mk(32'd0, 1, 1, 1, 1, 0, 0, 5), 0, "");

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // First phase: sender idles a third of the time, receiver most of it.
      snd_idle_pct  = 34;
      rcv_idle_pct <= 77;
      for (int i = 0; i < dir_req.size(); i++) send_item(dir_req[i], dir_typed[i], dir_text[i]);
      run_random(PHASE_ITEMS);
      wait_drained();

      // Second phase: the other way round.
      snd_idle_pct  = 77;
      rcv_idle_pct <= 34;
      run_random(PHASE_ITEMS);
      wait_drained();

      // Third phase: no idling, opened by a long receiver hold-off so that the block backs up.
      snd_idle_pct  = 0;
      rcv_idle_pct <= 0;
      hold_req     <= hold_req + 1;
      run_random(PHASE_ITEMS / 2);
      wait_drained();
      run_random(PHASE_ITEMS / 2);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Formatted %0d fields (%0d from the directed table), %0d characters checked,",
               accepted_n, dir_req.size(), chars_n);
      $display("across three back-pressure mixes and one long receiver hold-off.");
      if (errors == 0 && expected_chars.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
